[sv/bthin_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bthin_pkg
// Shared types, codes and the thinning decision for the binary image
// thinning block.
// ----------------------------------------------------------------------------
package bthin_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_THIN = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // configuration register indexes
  localparam logic REG_FRAME_ROWS = 1'b0;
  localparam logic REG_FRAME_COLS = 1'b1;

  // reset value of both frame size registers
  localparam logic [8:0] FRAME_RESET = 9'd256;

  // smallest frame span that has an interior
  localparam int MIN_SPAN = 3;

  // phases of one column step of the scan
  localparam logic [1:0] PH_TOP   = 2'd0;  // also writes back the finished pixel
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_BOT   = 2'd2;
  localparam logic [1:0] PH_SHIFT = 2'd3;

  localparam logic [15:0] PASS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] row_addr;
    logic [7:0] col_addr;
    logic       pixel_in;
  } bthin_in_t;

  typedef struct packed {
    logic        pixel_out;
    logic [15:0] pass_count;
    logic        status;
  } bthin_out_t;

  // Guo-Hall deletion test for a set center pixel.
  // Columns are {top, mid, bottom}; second selects the second sub-iteration.
  function automatic logic gh_clear(input logic [2:0] wl, input logic [2:0] wm,
                                    input logic [2:0] wr, input logic second);
    logic n, s, e, w, ne, se, sw, nw;
    logic t0, t1, t2, t3;
    logic [2:0] conn, n1, n2, nmin;
    logic m;
    n  = wm[2];
    s  = wm[0];
    e  = wr[1];
    w  = wl[1];
    ne = wr[2];
    se = wr[0];
    nw = wl[2];
    sw = wl[0];
    t0 = ~n & (ne | e);
    t1 = ~e & (se | s);
    t2 = ~s & (sw | w);
    t3 = ~w & (nw | n);
    conn = {2'b0, t0} + {2'b0, t1} + {2'b0, t2} + {2'b0, t3};
    n1 = {2'b0, nw | n} + {2'b0, ne | e} + {2'b0, se | s} + {2'b0, sw | w};
    n2 = {2'b0, n | ne} + {2'b0, e | se} + {2'b0, s | sw} + {2'b0, w | nw};
    nmin = (n1 < n2) ? n1 : n2;
    if (second) begin
      m = (n | ne | ~se) & e;
    end else begin
      m = (s | sw | ~nw) & w;
    end
    return (conn == 3'd1) && (nmin >= 3'd2) && (nmin <= 3'd3) && !m;
  endfunction

endpackage
`default_nettype wire

[sv/bthin_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bthin_ram
// One-bit-wide pixel memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bthin_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/binary_image_thinning.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_image_thinning
// Guo-Hall thinning of a binary frame held in on-chip pixel memory.
// Load and read words: result in the cycle after accept, one word per cycle while not busy.
// Thin word: each column step needs three reads of the single source read port
//   plus a shift.
// Frames without interior report one pass in the cycle after accept.
// Reset: frame size 256 x 256, control idle; pixel memories are not cleared.
// ----------------------------------------------------------------------------
module binary_image_thinning
  import bthin_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire bthin_in_t  in_word,
  output logic            done,
  output bthin_out_t      result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int URW   = $clog2(MAX_ROWS + 1);
  localparam int UCW   = $clog2(MAX_COLS + 1);
  localparam int KW    = $clog2(MAX_COLS + 2);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLS);

  state_t state;

  logic [8:0] frame_rows;
  logic [8:0] frame_cols;
  logic [URW-1:0] used_rows;
  logic [UCW-1:0] used_cols;

  // scan position and window
  logic [RW-1:0] r;
  logic [KW-1:0] k;
  logic [1:0]    ph;
  logic          second;
  logic          change;
  logic [15:0]   pcount;
  logic [2:0]    wl, wm, wr;
  logic          top_q, mid_q;
  logic [CW-1:0] wcol;
  logic          win_valid;

  // result staging
  logic        pix_sel;
  logic [15:0] res_count;
  logic        res_status;

  // memory ports
  logic          a_we, a_wdata, a_rdata;
  logic [AW-1:0] a_waddr, a_raddr;
  logic          b_we, b_rdata;
  logic [AW-1:0] scan_raddr, scan_waddr, cmd_addr;

  logic          accept;
  logic          in_frame;
  logic          no_interior;
  logic          scanning;
  logic [RW-1:0] row_last;
  logic [RW-1:0] rd_row;
  logic          rd_pix;
  logic          interior;
  logic          clr;
  logic          out_bit;
  logic          wr_now;
  logic [15:0]   pcount_inc;

  // clamp the configured size to the memory
  always_comb begin
    used_rows = (32'(frame_rows) > 32'(MAX_ROWS)) ? URW'(MAX_ROWS) : URW'(frame_rows);
    used_cols = (32'(frame_cols) > 32'(MAX_COLS)) ? UCW'(MAX_COLS) : UCW'(frame_cols);
  end

  assign accept      = start && !busy;
  assign scanning    = (state == ST_SCAN);
  assign busy        = scanning;
  assign cfg_ready   = !scanning;
  assign in_frame    = (32'(in_word.row_addr) < 32'(used_rows)) &&
                       (32'(in_word.col_addr) < 32'(used_cols));
  assign no_interior = (32'(used_rows) < 32'(MIN_SPAN)) || (32'(used_cols) < 32'(MIN_SPAN));
  assign row_last    = RW'(used_rows - URW'(1));
  assign cmd_addr    = AW'(RW'(in_word.row_addr)) * ROW_STRIDE + AW'(CW'(in_word.col_addr));

  // scan read row, clamped at the frame edges
  always_comb begin
    case (ph)
      PH_TOP:  rd_row = (r == '0) ? r : r - RW'(1);
      PH_BOT:  rd_row = (r == row_last) ? r : r + RW'(1);
      default: rd_row = r;
    endcase
  end

  assign scan_raddr = AW'(rd_row) * ROW_STRIDE + AW'(CW'(k));
  assign scan_waddr = AW'(r) * ROW_STRIDE + AW'(wcol);
  assign rd_pix     = second ? b_rdata : a_rdata;

  // decision for the pixel at the window center
  assign interior = (r != '0) && (r != row_last) && (wcol != '0) &&
                    (wcol != CW'(used_cols - UCW'(1)));
  assign clr      = interior && wm[1] && gh_clear(wl, wm, wr, second);
  assign out_bit  = wm[1] && !clr;
  assign wr_now   = scanning && (ph == PH_TOP) && win_valid;

  assign pcount_inc = (pcount == PASS_MAX) ? pcount : pcount + 16'd1;

  // first sub-iteration writes the pass memory, second writes back the image
  assign a_we    = scanning ? (wr_now && second)
                            : (accept && (in_word.cmd == CMD_LOAD) && in_frame);
  assign a_waddr = scanning ? scan_waddr : cmd_addr;
  assign a_wdata = scanning ? out_bit : in_word.pixel_in;
  assign a_raddr = scanning ? scan_raddr : cmd_addr;
  assign b_we    = wr_now && !second;

  bthin_ram #(.DEPTH(DEPTH), .AW(AW)) u_image (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  bthin_ram #(.DEPTH(DEPTH), .AW(AW)) u_pass (
    .clk   (clk),
    .we    (b_we),
    .waddr (scan_waddr),
    .wdata (out_bit),
    .raddr (scan_raddr),
    .rdata (b_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= FRAME_RESET;
      frame_cols <= FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        REG_FRAME_COLS: frame_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // window capture, no reset needed
  always_ff @(posedge clk) begin
    if (scanning) begin
      if (ph == PH_MID) begin
        top_q <= rd_pix;
      end
      if (ph == PH_BOT) begin
        mid_q <= rd_pix;
      end
      if (ph == PH_SHIFT) begin
        wl <= wm;
        wm <= wr;
        wr <= {top_q, mid_q, rd_pix};
        wcol <= CW'(k - KW'(1));
      end else if (ph == PH_TOP && k == KW'(used_cols)) begin
        // flush step for the last column of the row
        wl <= wm;
        wm <= wr;
        wr <= 3'b000;
        wcol <= CW'(used_cols - UCW'(1));
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      pix_sel    <= 1'b0;
      res_count  <= '0;
      res_status <= 1'b0;
      r          <= '0;
      k          <= '0;
      ph         <= PH_TOP;
      second     <= 1'b0;
      change     <= 1'b0;
      pcount     <= '0;
      win_valid  <= 1'b0;
    end else begin
      done    <= 1'b0;
      pix_sel <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_count  <= '0;
            res_status <= 1'b0;
            case (in_word.cmd)
              CMD_LOAD: begin
                done       <= 1'b1;
                res_status <= !in_frame;
              end
              CMD_READ: begin
                done       <= 1'b1;
                res_status <= !in_frame;
                pix_sel    <= in_frame;
              end
              CMD_THIN: begin
                if (no_interior) begin
                  done      <= 1'b1;
                  res_count <= 16'd1;
                end else begin
                  state     <= ST_SCAN;
                  r         <= '0;
                  k         <= '0;
                  ph        <= PH_TOP;
                  second    <= 1'b0;
                  change    <= 1'b0;
                  pcount    <= '0;
                  win_valid <= 1'b0;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (wr_now && clr) begin
            change <= 1'b1;
          end
          case (ph)
            PH_TOP: begin
              win_valid <= 1'b0;
              if (k == KW'(used_cols)) begin
                win_valid <= 1'b1;
                k         <= k + KW'(1);
              end else if (k == KW'(used_cols) + KW'(1)) begin
                // row finished
                k <= '0;
                if (r != row_last) begin
                  r <= r + RW'(1);
                end else if (!second) begin
                  second <= 1'b1;
                  r      <= '0;
                end else begin
                  pcount <= pcount_inc;
                  second <= 1'b0;
                  r      <= '0;
                  change <= 1'b0;
                  if (!(change || (wr_now && clr))) begin
                    state     <= ST_IDLE;
                    done      <= 1'b1;
                    res_count <= pcount_inc;
                  end
                end
              end else begin
                ph <= PH_MID;
              end
            end
            PH_MID: ph <= PH_BOT;
            PH_BOT: ph <= PH_SHIFT;
            default: begin
              win_valid <= (k != '0);
              k         <= k + KW'(1);
              ph        <= PH_TOP;
            end
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.pixel_out  = pix_sel && a_rdata;
  assign result.pass_count = res_count;
  assign result.status     = res_status;

endmodule
`default_nettype wire
